[src/mfat_pkg.sv]
// Shared types and constants for the motor feedback angle tracker.
package mfat_pkg;

    localparam int MOTOR_COUNT_DEF = 4;
    localparam int ID_W            = 11;
    localparam int ANGLE_W         = 16;
    localparam int TURN_W          = 32;
    localparam int TOTAL_W         = 32;
    localparam int TURN_SHIFT      = 13;   // one turn is 8192 counts
    localparam int HALF_TURN       = 4096;
    localparam int MOTOR_IDX_W     = 2;

    localparam logic [ID_W-1:0] BASE_ID_RESET = 11'd513;

    typedef enum logic [1:0] {
        MODE_FRAME       = 2'd0,
        MODE_CAP_OFFSET  = 2'd1,
        MODE_CAP_ZERO    = 2'd2
    } t_mode;

    typedef struct packed {
        logic [ANGLE_W-1:0] prev_angle;
        logic [TURN_W-1:0]  turn;
        logic [ANGLE_W-1:0] offset;
        logic [TOTAL_W-1:0] total;
        logic [TOTAL_W-1:0] zero;
    } t_motor_rec;

endpackage

[src/motor_feedback_angle_tracker.sv]
// Top level of the motor feedback angle tracker.
// Takes one transaction per clock cycle while o_stall is low and returns the
// result of a matching feedback frame through the stage 1, stage 2 and output
// registers (held while the output is stalled). Per-motor state lives in a
// small synchronous memory read at acceptance and written back from the next
// stage; a bypass register covers frames for the same motor on consecutive
// cycles. Capture commands mark every motor at once, so no sweep over the motors
// is needed, and the block is ready straight out of reset with no clearing pass.
module motor_feedback_angle_tracker #(
    parameter int MOTOR_COUNT = mfat_pkg::MOTOR_COUNT_DEF,
    localparam int IW = (MOTOR_COUNT > 1) ? $clog2(MOTOR_COUNT) : 1
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_we,
    input  logic [mfat_pkg::ID_W-1:0]              i_cfg_data,
    input  logic                                   i_valid,
    output logic                                   o_stall,
    input  logic [1:0]                             i_mode,
    input  logic [mfat_pkg::ID_W-1:0]              i_frame_id,
    input  logic [mfat_pkg::ANGLE_W-1:0]           i_angle_raw,
    input  logic signed [15:0]                     i_speed_raw,
    input  logic signed [15:0]                     i_current_raw,
    input  logic [7:0]                             i_hall_raw,
    output logic                                   o_valid,
    input  logic                                   i_stall,
    output logic [mfat_pkg::MOTOR_IDX_W-1:0]       o_motor_index,
    output logic [mfat_pkg::ANGLE_W-1:0]           o_rotor_angle,
    output logic signed [15:0]                     o_rotor_speed,
    output logic signed [15:0]                     o_rotor_current,
    output logic [7:0]                             o_hall_value,
    output logic signed [mfat_pkg::TURN_W-1:0]     o_turn_count,
    output logic signed [mfat_pkg::TOTAL_W-1:0]    o_total_pos,
    output logic signed [mfat_pkg::TOTAL_W-1:0]    o_relative_angle
);

    localparam int AW = mfat_pkg::ANGLE_W;
    localparam int TW = mfat_pkg::TURN_W;
    localparam int SW = mfat_pkg::TOTAL_W;
    localparam int SH = mfat_pkg::TURN_SHIFT;

    logic [mfat_pkg::ID_W-1:0] r_base_id;
    logic [mfat_pkg::ID_W-1:0] id_diff;
    logic                      in_range;
    logic                      is_frame;
    logic                      cap_offset;
    logic                      cap_zero;
    logic                      accept;
    logic                      s1_load;
    logic                      mv1;
    logic                      mv2;

    // stage 1: memory data arrives, update computed
    logic            r_v1;
    logic [IW-1:0]   r1_idx;
    logic [AW-1:0]   r1_angle;
    logic [15:0]     r1_speed;
    logic [15:0]     r1_current;
    logic [7:0]      r1_hall;

    mfat_pkg::t_motor_rec rd_rec;
    mfat_pkg::t_motor_rec wr_rec;
    logic signed [AW:0]   delta;
    logic signed [AW:0]   ang_diff;
    logic [TW-1:0]        turn_new;
    logic [SW-1:0]        total;
    logic                 wr_en;

    // stage 2
    logic            r_v2;
    logic [IW-1:0]   r2_idx;
    logic [AW-1:0]   r2_angle;
    logic [15:0]     r2_speed;
    logic [15:0]     r2_current;
    logic [7:0]      r2_hall;
    logic [TW-1:0]   r2_turn;
    logic [SW-1:0]   r2_total;
    logic [SW-1:0]   r2_zero;

    // output register
    logic            r_v3;
    logic [IW-1:0]   r3_idx;
    logic [AW-1:0]   r3_angle;
    logic [15:0]     r3_speed;
    logic [15:0]     r3_current;
    logic [7:0]      r3_hall;
    logic [TW-1:0]   r3_turn;
    logic [SW-1:0]   r3_total;
    logic [SW-1:0]   r3_rel;

    assign mv2     = !r_v3 || !i_stall;
    assign mv1     = !r_v2 || mv2;
    assign o_stall = r_v1 && !mv1;
    assign accept  = i_valid && !o_stall;

    always_comb begin
        is_frame   = 1'b0;
        cap_offset = 1'b0;
        cap_zero   = 1'b0;
        unique case (mfat_pkg::t_mode'(i_mode))
            mfat_pkg::MODE_FRAME:      is_frame   = 1'b1;
            mfat_pkg::MODE_CAP_OFFSET: cap_offset = 1'b1;
            mfat_pkg::MODE_CAP_ZERO:   cap_zero   = 1'b1;
            default: ;
        endcase
    end

    assign id_diff  = i_frame_id - r_base_id;
    assign in_range = (i_frame_id >= r_base_id) &&
                      (id_diff < mfat_pkg::ID_W'(MOTOR_COUNT));
    assign s1_load  = accept && is_frame && in_range;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_id <= mfat_pkg::BASE_ID_RESET;
        end else if (i_cfg_we) begin
            r_base_id <= i_cfg_data;
        end
    end

    mfat_state #(
        .MOTOR_COUNT (MOTOR_COUNT)
    ) u_state (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_rd_en      (s1_load),
        .i_rd_addr    (id_diff[IW-1:0]),
        .o_rd_rec     (rd_rec),
        .i_wr_en      (wr_en),
        .i_wr_addr    (r1_idx),
        .i_wr_rec     (wr_rec),
        .i_cap_offset (accept && cap_offset),
        .i_cap_zero   (accept && cap_zero)
    );

    // stage 1 update: unwrap turns and form the new total
    always_comb begin
        delta    = $signed({1'b0, r1_angle}) - $signed({1'b0, rd_rec.prev_angle});
        ang_diff = $signed({1'b0, r1_angle}) - $signed({1'b0, rd_rec.offset});
        if (delta > (AW+1)'(mfat_pkg::HALF_TURN)) begin
            turn_new = rd_rec.turn - TW'(1);
        end else if (delta < -(AW+1)'(mfat_pkg::HALF_TURN)) begin
            turn_new = rd_rec.turn + TW'(1);
        end else begin
            turn_new = rd_rec.turn;
        end
        total = {turn_new[SW-SH-1:0], {SH{1'b0}}} +
                {{(SW-AW-1){ang_diff[AW]}}, ang_diff};
        wr_rec.prev_angle = r1_angle;
        wr_rec.turn       = turn_new;
        wr_rec.offset     = rd_rec.offset;
        wr_rec.total      = total;
        wr_rec.zero       = rd_rec.zero;
    end

    assign wr_en = r_v1 && mv1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            // stage 1 takes a new transaction whenever it is empty or moving on
            if (!o_stall) begin
                r_v1 <= s1_load;
            end
            if (mv1) begin
                r_v2 <= r_v1;
            end
            if (mv2) begin
                r_v3 <= r_v2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_load) begin
            r1_idx     <= id_diff[IW-1:0];
            r1_angle   <= i_angle_raw;
            r1_speed   <= i_speed_raw;
            r1_current <= i_current_raw;
            r1_hall    <= i_hall_raw;
        end
        if (wr_en) begin
            r2_idx     <= r1_idx;
            r2_angle   <= r1_angle;
            r2_speed   <= r1_speed;
            r2_current <= r1_current;
            r2_hall    <= r1_hall;
            r2_turn    <= turn_new;
            r2_total   <= total;
            r2_zero    <= rd_rec.zero;
        end
        if (mv2 && r_v2) begin
            r3_idx     <= r2_idx;
            r3_angle   <= r2_angle;
            r3_speed   <= r2_speed;
            r3_current <= r2_current;
            r3_hall    <= r2_hall;
            r3_turn    <= r2_turn;
            r3_total   <= r2_total;
            r3_rel     <= r2_total - r2_zero;
        end
    end

    assign o_valid          = r_v3;
    assign o_motor_index    = mfat_pkg::MOTOR_IDX_W'(r3_idx);
    assign o_rotor_angle    = r3_angle;
    assign o_rotor_speed    = r3_speed;
    assign o_rotor_current  = r3_current;
    assign o_hall_value     = r3_hall;
    assign o_turn_count     = r3_turn;
    assign o_total_pos      = r3_total;
    assign o_relative_angle = r3_rel;

endmodule

[src/mfat_state.sv]
// Per-motor state memory with write bypass, valid bits and lazy capture flags.
module mfat_state #(
    parameter int MOTOR_COUNT = mfat_pkg::MOTOR_COUNT_DEF,
    localparam int IW = (MOTOR_COUNT > 1) ? $clog2(MOTOR_COUNT) : 1
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_rd_en,
    input  logic [IW-1:0]        i_rd_addr,
    output mfat_pkg::t_motor_rec o_rd_rec,
    input  logic                 i_wr_en,
    input  logic [IW-1:0]        i_wr_addr,
    input  mfat_pkg::t_motor_rec i_wr_rec,
    input  logic                 i_cap_offset,
    input  logic                 i_cap_zero
);

    mfat_pkg::t_motor_rec r_mem [MOTOR_COUNT];
    mfat_pkg::t_motor_rec r_mem_q;
    mfat_pkg::t_motor_rec r_fwd_rec;
    mfat_pkg::t_motor_rec rec;

    logic [IW-1:0]          r_rd_addr;
    logic                   r_rd_valid;
    logic                   r_fwd_hit;
    logic [MOTOR_COUNT-1:0] r_valid;
    logic [MOTOR_COUNT-1:0] r_stale_off;
    logic [MOTOR_COUNT-1:0] r_stale_zero;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_rec;
        end
        if (i_rd_en) begin
            r_mem_q   <= r_mem[i_rd_addr];
            r_fwd_rec <= i_wr_rec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_addr    <= '0;
            r_rd_valid   <= 1'b0;
            r_fwd_hit    <= 1'b0;
            r_valid      <= '0;
            r_stale_off  <= '0;
            r_stale_zero <= '0;
        end else begin
            if (i_rd_en) begin
                r_rd_addr  <= i_rd_addr;
                r_rd_valid <= r_valid[i_rd_addr];
                // catch a write to the same entry at the read edge
                r_fwd_hit  <= i_wr_en && (i_wr_addr == i_rd_addr);
            end
            for (int k = 0; k < MOTOR_COUNT; k++) begin
                if (i_wr_en && (i_wr_addr == IW'(k))) begin
                    r_valid[k] <= 1'b1;
                end
                // a capture after a write in the same cycle sees the new entry
                if (i_cap_offset) begin
                    r_stale_off[k] <= 1'b1;
                end else if (i_wr_en && (i_wr_addr == IW'(k))) begin
                    r_stale_off[k] <= 1'b0;
                end
                if (i_cap_zero) begin
                    r_stale_zero[k] <= 1'b1;
                end else if (i_wr_en && (i_wr_addr == IW'(k))) begin
                    r_stale_zero[k] <= 1'b0;
                end
            end
        end
    end

    always_comb begin
        if (r_fwd_hit) begin
            rec = r_fwd_rec;
        end else if (r_rd_valid) begin
            rec = r_mem_q;
        end else begin
            rec = '0;
        end
        o_rd_rec = rec;
        // an entry untouched since a capture takes its captured value from itself
        if (r_stale_off[r_rd_addr]) begin
            o_rd_rec.offset = rec.prev_angle;
        end
        if (r_stale_zero[r_rd_addr]) begin
            o_rd_rec.zero = rec.total;
        end
    end

endmodule
